/* rtl/core/plane_pair_intersection_line_assert.svh */
// Assertion macros for the plane pair intersection line block.
// Used by plane_pair_intersection_line.sv; needs no other file.
`ifndef PLANE_PAIR_INTERSECTION_LINE_ASSERT_SVH
`define PLANE_PAIR_INTERSECTION_LINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition in the same cycle
`define PPIL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");
// condition after the delay given by dly
`define PPIL_ASSERT_DLY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("assertion failed: label");
`else
`define PPIL_ASSERT_IMP(label, clk, rst, ante, cons)
`define PPIL_ASSERT_DLY(label, clk, rst, ante, dly, cons)
`endif
`endif

/* rtl/core/ppil_pkg.sv */
// Shared constants of the plane pair intersection line block.
// No dependencies.
`default_nettype none
package ppil_pkg;
   localparam int unsigned LIMIT_WIDTH = 48;
   localparam logic [LIMIT_WIDTH-1:0] PARALLEL_LIMIT_RESET = 48'd281474977;
   // cycles through ppil_wmul
   localparam int unsigned WMUL_LATENCY = 2;
endpackage
`default_nettype wire

/* rtl/core/ppil_wmul.sv */
// Two-stage signed multiplier for wide operands, built from four narrow
// partial products. Depends on nothing.
`default_nettype none
module ppil_wmul #(
   parameter int unsigned WIDTH = 49,
   parameter int unsigned LOW   = 24
) (
   input  logic                      clock,
   input  logic signed [WIDTH-1:0]   a,
   input  logic signed [WIDTH-1:0]   b,
   output logic signed [2*WIDTH-1:0] p
);
   localparam int unsigned HIGH = WIDTH - LOW;

   logic signed [HIGH-1:0]      a_hi, b_hi;
   logic signed [LOW:0]         a_lo, b_lo;
   logic signed [2*HIGH-1:0]    hh_ff, hh_in;
   logic signed [HIGH+LOW:0]    hl_ff, hl_in, lh_ff, lh_in;
   logic [2*LOW-1:0]            ll_ff, ll_in;
   logic signed [2*WIDTH-1:0]   hh_x, hl_x, lh_x, ll_x, p_in;

   // split operands: signed upper part, zero-extended lower part
   assign a_hi = a[WIDTH-1:LOW];
   assign b_hi = b[WIDTH-1:LOW];
   assign a_lo = $signed({1'b0, a[LOW-1:0]});
   assign b_lo = $signed({1'b0, b[LOW-1:0]});

   // form partial products
   always_comb begin
      hh_in = a_hi * b_hi;
      hl_in = a_hi * b_lo;
      lh_in = a_lo * b_hi;
      ll_in = a[LOW-1:0] * b[LOW-1:0];
   end

   // combine partial products
   always_comb begin
      hh_x = hh_ff;
      hl_x = hl_ff;
      lh_x = lh_ff;
      ll_x = $signed({{(2*WIDTH-2*LOW){1'b0}}, ll_ff});
      p_in = (hh_x <<< (2*LOW)) + ((hl_x + lh_x) <<< LOW) + ll_x;
   end

   always_ff @(posedge clock) begin
      hh_ff <= hh_in;
      hl_ff <= hl_in;
      lh_ff <= lh_in;
      ll_ff <= ll_in;
      p     <= p_in;
   end
endmodule
`default_nettype wire

/* rtl/core/plane_pair_intersection_line.sv */
// Intersection line of two planes in signed fixed point, fully pipelined.
// Depends on ppil_pkg, ppil_wmul and plane_pair_intersection_line_assert.svh.
//
//   channel   ports        handshake
//   request   req_*        start, busy (busy is always low)
//   response  rsp_*        rsp_valid strobe, one cycle per word
//   config    csr_*        csr_wr_en, no read-back
//
// One plane pair is taken every cycle. The quotients come from a restoring
// divider that retires one quotient bit per stage.
// Reset (synchronous) clears the valid line and loads the parallel limit.
// The pipeline never stalls: words leave in the order the pairs were taken.
`default_nettype none
module plane_pair_intersection_line #(
   parameter int unsigned COORD_WIDTH = 24,
   parameter int unsigned FRAC_BITS   = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_nx,
   input  logic signed [COORD_WIDTH-1:0] req_first_ny,
   input  logic signed [COORD_WIDTH-1:0] req_first_nz,
   input  logic signed [COORD_WIDTH-1:0] req_first_dist,
   input  logic signed [COORD_WIDTH-1:0] req_second_nx,
   input  logic signed [COORD_WIDTH-1:0] req_second_ny,
   input  logic signed [COORD_WIDTH-1:0] req_second_nz,
   input  logic signed [COORD_WIDTH-1:0] req_second_dist,
   input  logic                          csr_wr_en,
   input  logic [ppil_pkg::LIMIT_WIDTH-1:0] csr_wr_data,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic signed [COORD_WIDTH-1:0] rsp_start_x,
   output logic signed [COORD_WIDTH-1:0] rsp_start_y,
   output logic signed [COORD_WIDTH-1:0] rsp_start_z,
   output logic signed [COORD_WIDTH-1:0] rsp_dir_x,
   output logic signed [COORD_WIDTH-1:0] rsp_dir_y,
   output logic signed [COORD_WIDTH-1:0] rsp_dir_z,
   output logic                          rsp_clipped
);
   import ppil_pkg::*;

   localparam int unsigned W    = COORD_WIDTH;
   localparam int unsigned F    = FRAC_BITS;
   localparam int unsigned CW   = 2*W + 1;          // cross product terms
   localparam int unsigned PW   = 2*CW;             // wide products
   localparam int unsigned DW   = PW;               // determinant, unsigned
   localparam int unsigned XW   = PW + 1;           // numerator cross terms
   localparam int unsigned MW   = XW + F + 2;       // dividend
   localparam int unsigned CMPW = MW + W + 2;       // divider compare width
   localparam int unsigned LAT  = WMUL_LATENCY + W + 6;
   localparam int unsigned SL   = LAT - 3;

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] z;
      logic                clip;
   } side_type;

   // {clip, value} of a magnitude and sign, saturated to W bits
   function automatic logic [W:0] sat(input logic ovf, input logic [W-1:0] mag,
                                      input logic neg);
      logic          clip;
      logic [W-1:0]  val;
      clip = ovf || (neg ? (mag[W-1] && (|mag[W-2:0])) : mag[W-1]);
      if (clip) begin
         val = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         val = neg ? (~mag + 1'b1) : mag;
      end
      return {clip, val};
   endfunction

   logic                       accept;
   logic [LIMIT_WIDTH-1:0]     lim_ff;
   logic [LAT-1:0]             vld_ff;
   logic signed [2*W-1:0]      prod_ff [0:11];
   logic signed [CW-1:0]       c_ff [0:2];
   logic signed [CW-1:0]       v_ff [0:2];
   logic signed [PW-1:0]       sq [0:2];
   logic signed [PW-1:0]       pr [0:5];
   logic [DW-1:0]              det_ff;
   logic signed [XW-1:0]       x_ff [0:2];
   side_type                   side_in;
   side_type                   sd_ff [0:SL-1];
   logic [MW-1:0]              rem_ff [0:W+1][0:2];
   logic [W:0]                 quo_ff [0:W+1][0:2];
   logic                       neg_ff [0:W+1][0:2];
   logic [DW:0]                dv_ff [0:W+1];
   logic                       fnd_ff [0:W+1];
   logic [W:0]                 res [0:2];
   logic                       same_normal;
   logic                       rsp_zero;

   assign accept = start && !busy;
   assign busy   = 1'b0;

   // hold the parallel limit
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= PARALLEL_LIMIT_RESET;
      end else if (csr_wr_en) begin
         lim_ff <= csr_wr_data;
      end
   end

   // advance the valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // stage 1: narrow products for n1 x n2 and v = d2*n1 - d1*n2
   always_ff @(posedge clock) begin
      prod_ff[0]  <= req_first_ny * req_second_nz;
      prod_ff[1]  <= req_first_nz * req_second_ny;
      prod_ff[2]  <= req_first_nz * req_second_nx;
      prod_ff[3]  <= req_first_nx * req_second_nz;
      prod_ff[4]  <= req_first_nx * req_second_ny;
      prod_ff[5]  <= req_first_ny * req_second_nx;
      prod_ff[6]  <= req_second_dist * req_first_nx;
      prod_ff[7]  <= req_first_dist * req_second_nx;
      prod_ff[8]  <= req_second_dist * req_first_ny;
      prod_ff[9]  <= req_first_dist * req_second_ny;
      prod_ff[10] <= req_second_dist * req_first_nz;
      prod_ff[11] <= req_first_dist * req_second_nz;
   end

   // stage 2: differences
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         c_ff[k] <= CW'(prod_ff[2*k]) - CW'(prod_ff[2*k+1]);
         v_ff[k] <= CW'(prod_ff[6+2*k]) - CW'(prod_ff[7+2*k]);
      end
   end

   // squares of the cross product (sum is the determinant) and v x c
   for (genvar k = 0; k < 3; k++) begin : g_mul
      ppil_wmul #(.WIDTH(CW), .LOW(W)) u_sq (
         .clock(clock), .a(c_ff[k]), .b(c_ff[k]), .p(sq[k])
      );
      ppil_wmul #(.WIDTH(CW), .LOW(W)) u_pa (
         .clock(clock), .a(v_ff[(k+1)%3]), .b(c_ff[(k+2)%3]), .p(pr[2*k])
      );
      ppil_wmul #(.WIDTH(CW), .LOW(W)) u_pb (
         .clock(clock), .a(v_ff[(k+2)%3]), .b(c_ff[(k+1)%3]), .p(pr[2*k+1])
      );
   end

   // direction: round cross product to the input format, ties away from zero
   always_comb begin
      logic [CW-1:0] mag [0:2];
      logic [CW-1:0] rnd [0:2];
      logic [W:0]    s [0:2];
      for (int k = 0; k < 3; k++) begin
         mag[k] = c_ff[k][CW-1] ? CW'(-c_ff[k]) : CW'(c_ff[k]);
         rnd[k] = (mag[k] + (CW'(1) << (F-1))) >> F;
         s[k]   = sat(|rnd[k][CW-1:W], rnd[k][W-1:0], c_ff[k][CW-1]);
      end
      side_in.x    = s[0][W-1:0];
      side_in.y    = s[1][W-1:0];
      side_in.z    = s[2][W-1:0];
      side_in.clip = s[0][W] || s[1][W] || s[2][W];
   end

   // carry direction alongside the divider
   always_ff @(posedge clock) begin
      sd_ff[0] <= side_in;
      for (int i = 1; i < SL; i++) begin
         sd_ff[i] <= sd_ff[i-1];
      end
   end

   // stage after multipliers: determinant and numerator terms
   always_ff @(posedge clock) begin
      det_ff <= DW'($unsigned(sq[0])) + DW'($unsigned(sq[1])) + DW'($unsigned(sq[2]));
      for (int k = 0; k < 3; k++) begin
         x_ff[k] <= XW'(pr[2*k]) - XW'(pr[2*k+1]);
      end
   end

   // divider: load dividend, then one quotient bit per stage, high bit first
   for (genvar j = 0; j <= W + 1; j++) begin : g_div
      if (j == 0) begin : g_load
         always_ff @(posedge clock) begin
            for (int l = 0; l < 3; l++) begin
               logic [XW-1:0] ax;
               ax = x_ff[l][XW-1] ? XW'(-x_ff[l]) : XW'(x_ff[l]);
               rem_ff[0][l] <= (MW'(ax) << (F+1)) + MW'(det_ff);
               quo_ff[0][l] <= '0;
               neg_ff[0][l] <= x_ff[l][XW-1];
            end
            dv_ff[0]  <= {det_ff, 1'b0};
            fnd_ff[0] <= (det_ff != '0) &&
                         (det_ff >= {{(DW-LIMIT_WIDTH){1'b0}}, lim_ff});
         end
      end else begin : g_step
         always_ff @(posedge clock) begin
            for (int l = 0; l < 3; l++) begin
               logic [CMPW-1:0] num, den;
               num = CMPW'(rem_ff[j-1][l]);
               den = CMPW'(dv_ff[j-1]) << (W + 1 - j);
               if (num >= den) begin
                  rem_ff[j][l] <= MW'(num - den);
                  quo_ff[j][l] <= quo_ff[j-1][l] | ((W+1)'(1) << (W + 1 - j));
               end else begin
                  rem_ff[j][l] <= rem_ff[j-1][l];
                  quo_ff[j][l] <= quo_ff[j-1][l];
               end
               neg_ff[j][l] <= neg_ff[j-1][l];
            end
            dv_ff[j]  <= dv_ff[j-1];
            fnd_ff[j] <= fnd_ff[j-1];
         end
      end
   end

   // saturate quotients
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         res[l] = sat(quo_ff[W+1][l][W], quo_ff[W+1][l][W-1:0], neg_ff[W+1][l]);
      end
   end

   // output register; drop all fields of a parallel pair
   always_ff @(posedge clock) begin
      rsp_found   <= fnd_ff[W+1];
      if (fnd_ff[W+1]) begin
         rsp_start_x <= res[0][W-1:0];
         rsp_start_y <= res[1][W-1:0];
         rsp_start_z <= res[2][W-1:0];
         rsp_dir_x   <= sd_ff[SL-1].x;
         rsp_dir_y   <= sd_ff[SL-1].y;
         rsp_dir_z   <= sd_ff[SL-1].z;
         rsp_clipped <= res[0][W] || res[1][W] || res[2][W] || sd_ff[SL-1].clip;
      end else begin
         rsp_start_x <= '0;
         rsp_start_y <= '0;
         rsp_start_z <= '0;
         rsp_dir_x   <= '0;
         rsp_dir_y   <= '0;
         rsp_dir_z   <= '0;
         rsp_clipped <= 1'b0;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // conditions watched by the checks below
   assign same_normal = (req_first_nx == req_second_nx) &&
                        (req_first_ny == req_second_ny) &&
                        (req_first_nz == req_second_nz);
   assign rsp_zero    = (rsp_start_x == '0) && (rsp_start_y == '0) &&
                        (rsp_start_z == '0) && (rsp_dir_x == '0) &&
                        (rsp_dir_y == '0) && (rsp_dir_z == '0) && !rsp_clipped;

`include "plane_pair_intersection_line_assert.svh"

   `PPIL_ASSERT_DLY(a_latency, clock, reset, accept, LAT, rsp_valid)
   `PPIL_ASSERT_DLY(a_same_normal, clock, reset, accept && same_normal, LAT, rsp_valid && !rsp_found)
   `PPIL_ASSERT_IMP(a_parallel_zero, clock, reset, rsp_valid && !rsp_found, rsp_zero)
endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for plane_pair_intersection_line: drives plane pairs, predicts
// each result word with wide exact integer math and compares it with the response.
// Depends on ppil_pkg and the RTL of plane_pair_intersection_line.
module testbench;
   import ppil_pkg::*;

   localparam int CW = 24;
   localparam int FB = 12;
   localparam int RUN_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 40;

   typedef logic signed [255:0] wide_type;
   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type n1x, n1y, n1z, d1, n2x, n2y, n2z, d2;
   } plane_pair_type;

   typedef struct {
      logic      found;
      coord_type sx, sy, sz, dx, dy, dz;
      logic      clipped;
   } line_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   coord_type req_first_nx = 0, req_first_ny = 0, req_first_nz = 0, req_first_dist = 0;
   coord_type req_second_nx = 0, req_second_ny = 0, req_second_nz = 0, req_second_dist = 0;
   logic csr_wr_en = 0;
   logic [LIMIT_WIDTH-1:0] csr_wr_data = 0;
   logic rsp_valid, rsp_found, rsp_clipped;
   coord_type rsp_start_x, rsp_start_y, rsp_start_z, rsp_dir_x, rsp_dir_y, rsp_dir_z;

   line_type lines_due[$];
   logic [LIMIT_WIDTH-1:0] limit_now = PARALLEL_LIMIT_RESET;
   int error_count = 0;
   int cycle_count = 0;
   int idle_pct = 0;

   plane_pair_intersection_line uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_nx(req_first_nx), .req_first_ny(req_first_ny),
      .req_first_nz(req_first_nz), .req_first_dist(req_first_dist),
      .req_second_nx(req_second_nx), .req_second_ny(req_second_ny),
      .req_second_nz(req_second_nz), .req_second_dist(req_second_dist),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found),
      .rsp_start_x(rsp_start_x), .rsp_start_y(rsp_start_y), .rsp_start_z(rsp_start_z),
      .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y), .rsp_dir_z(rsp_dir_z),
      .rsp_clipped(rsp_clipped)
   );

   always #5 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // round to nearest, ties away from zero; den positive
   function automatic wide_type round_quot(wide_type num, wide_type den);
      wide_type mag, q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   // clamp to the coordinate range, flag the clamp
   function automatic coord_type clamp_coord(wide_type v, inout logic clip);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (CW - 1)) - 1;
      lo = -(wide_type'(1) <<< (CW - 1));
      if (v > hi) begin
         clip = 1;
         return coord_type'(hi);
      end
      if (v < lo) begin
         clip = 1;
         return coord_type'(lo);
      end
      return coord_type'(v);
   endfunction

   function automatic line_type solve_line(plane_pair_type pp);
      wide_type p[3], q[3];
      wide_type e1, e2, n00, n01, n11, det, adet, lim, num0, num1, n, one;
      line_type r;
      logic clip;
      p[0] = pp.n1x; p[1] = pp.n1y; p[2] = pp.n1z;
      q[0] = pp.n2x; q[1] = pp.n2y; q[2] = pp.n2z;
      e1 = pp.d1; e2 = pp.d2;
      one = wide_type'(1) <<< FB;
      clip = 0;
      r = '{default: 0};
      n00 = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
      n01 = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
      n11 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
      det = n00 * n11 - n01 * n01;
      adet = (det < 0) ? -det : det;
      lim = $signed({208'b0, limit_now});
      if (det == 0 || adet < lim) return r;
      num0 = n01 * e2 - n11 * e1;
      num1 = n01 * e1 - n00 * e2;
      n = (num0 * p[0] + num1 * q[0]) * one;
      if (det < 0) n = -n;
      r.sx = clamp_coord(round_quot(n, adet), clip);
      n = (num0 * p[1] + num1 * q[1]) * one;
      if (det < 0) n = -n;
      r.sy = clamp_coord(round_quot(n, adet), clip);
      n = (num0 * p[2] + num1 * q[2]) * one;
      if (det < 0) n = -n;
      r.sz = clamp_coord(round_quot(n, adet), clip);
      r.dx = clamp_coord(round_quot(p[1] * q[2] - p[2] * q[1], one), clip);
      r.dy = clamp_coord(round_quot(p[2] * q[0] - p[0] * q[2], one), clip);
      r.dz = clamp_coord(round_quot(p[0] * q[1] - p[1] * q[0], one), clip);
      r.found = 1;
      r.clipped = clip;
      return r;
   endfunction

   task automatic check_field(string name, coord_type want, coord_type got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      line_type w;
      if (!reset && rsp_valid) begin
         if (lines_due.size() == 0) begin
            $display("%0t unexpected word: actual found %0b", $time, rsp_found);
            error_count++;
         end else begin
            w = lines_due.pop_front();
            check_field("found", coord_type'(w.found), coord_type'(rsp_found));
            check_field("start_x", w.sx, rsp_start_x);
            check_field("start_y", w.sy, rsp_start_y);
            check_field("start_z", w.sz, rsp_start_z);
            check_field("dir_x", w.dx, rsp_dir_x);
            check_field("dir_y", w.dy, rsp_dir_y);
            check_field("dir_z", w.dz, rsp_dir_z);
            check_field("clipped", coord_type'(w.clipped), coord_type'(rsp_clipped));
         end
      end
   end

   // present one pair, hold until taken, then idle at the current rate
   task automatic send_pair(plane_pair_type pp);
      @(negedge clock);
      req_first_nx = pp.n1x; req_first_ny = pp.n1y;
      req_first_nz = pp.n1z; req_first_dist = pp.d1;
      req_second_nx = pp.n2x; req_second_ny = pp.n2y;
      req_second_nz = pp.n2z; req_second_dist = pp.d2;
      start = 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      lines_due.push_back(solve_line(pp));
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 0;
         @(posedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      start = 0;
      while (lines_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_WIDTH-1:0] v);
      drain();
      @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
      limit_now = v;
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   function automatic plane_pair_type pair_of(int a, int b, int c, int d,
                                              int e, int f, int g, int h);
      plane_pair_type pp;
      pp = '{coord_type'(a), coord_type'(b), coord_type'(c), coord_type'(d),
             coord_type'(e), coord_type'(f), coord_type'(g), coord_type'(h)};
      return pp;
   endfunction

   task automatic test_directed;
      idle_pct = 0;
      // reset limit: orthogonal unit normals, identical planes, zero normals
      send_pair(pair_of(4096, 0, 0, 4096, 0, 4096, 0, -8192));
      send_pair(pair_of(4096, 4096, 0, 100, 4096, 4096, 0, 100));
      send_pair(pair_of(0, 0, 0, 5, 0, 0, 0, 7));
      send_pair(pair_of(4096, 0, 0, 0, 4096, 1, 0, 0));
      send_pair(pair_of(-8388608, -8388608, -8388608, -8388608,
                        8388607, 8388607, -8388608, 8388607));
      send_pair(pair_of(8388607, 0, 0, 8388607, 0, 8388607, 0, -8388608));
      send_pair(pair_of(1, 0, 0, 8388607, 0, 1, 0, 8388607));
      send_pair(pair_of(3, 5, 7, 1, -2, 9, 4, -1));
      // zero determinant stays parallel with a zero limit
      write_limit('0);
      send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pair_of(2048, 2048, 2048, 1, 4096, 4096, 4096, 3));
      send_pair(pair_of(1, 0, 0, 1, 0, 1, 0, 1));
      send_pair(pair_of(1, 1, 0, -8388608, 1, 0, 1, 8388607));
      // largest limit
      write_limit('1);
      send_pair(pair_of(4096, 0, 0, 4096, 0, 4096, 0, -8192));
      send_pair(pair_of(8388607, 0, 0, 1, 0, 8388607, 0, 1));
      send_pair(pair_of(-8388608, 0, 0, 1, 0, -8388608, 0, 1));
      drain();
   endtask

   // random phase: mix of wide, moderate and near parallel pairs
   task automatic test_random(int count, int pct);
      plane_pair_type pp;
      int kind;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(2);
         if (kind == 0) begin
            pp = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), rand_coord()};
         end else if (kind == 1) begin
            pp = pair_of($urandom_range(16384) - 8192, $urandom_range(16384) - 8192,
                         $urandom_range(16384) - 8192, $urandom_range(65536) - 32768,
                         $urandom_range(16384) - 8192, $urandom_range(16384) - 8192,
                         $urandom_range(16384) - 8192, $urandom_range(65536) - 32768);
         end else begin
            pp.n1x = coord_type'($urandom_range(8192) - 4096);
            pp.n1y = coord_type'($urandom_range(8192) - 4096);
            pp.n1z = coord_type'($urandom_range(8192) - 4096);
            pp.d1 = rand_coord();
            pp.n2x = pp.n1x + coord_type'($urandom_range(4) - 2);
            pp.n2y = pp.n1y + coord_type'($urandom_range(4) - 2);
            pp.n2z = pp.n1z + coord_type'($urandom_range(4) - 2);
            pp.d2 = rand_coord();
         end
         send_pair(pp);
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      write_limit(PARALLEL_LIMIT_RESET);
      test_directed();
      write_limit(PARALLEL_LIMIT_RESET);
      test_random(175, 0);
      write_limit(48'd0);
      test_random(175, 88);
      write_limit(LIMIT_WIDTH'({$urandom, $urandom}));
      test_random(175, 38);
      write_limit(48'd1 << 36);
      test_random(175, 0);
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ppil_pkg.sv
rtl/core/ppil_wmul.sv
rtl/core/plane_pair_intersection_line.sv
bench/testbench.sv
